// ===== hdl/bpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpcr_pkg: shared types and constants of the box pair contact resolver
// Holds the sideband word that rides along the pipeline, axis codes and the
// fixed constants of the overlap and rounding arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcr_pkg;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Overlap in LSB/100: 51*S - 50*|D2| - 300
    localparam int OV_S_GAIN = 51;
    localparam int OV_D_GAIN = 50;
    localparam int OV_MARGIN = 300;

    // Rounded share: (|push| + bias) >> shift, then divided by 25
    localparam int BIAS_WHOLE  = 50;
    localparam int BIAS_HALF   = 100;
    localparam int SHIFT_WHOLE = 2;
    localparam int SHIFT_HALF  = 3;
    localparam int DIV_BASE    = 25;

    // Divider: register stages of the reciprocal multiply
    localparam int DIV_STAGES = 2;

    // Per-word control that travels beside the datapath
    typedef struct packed {
        logic       contact;
        logic       pushed;
        logic [1:0] axis;
        logic       neg;     // push is negative along its axis
        logic       half;    // both boxes move, split the push
        logic       mv_a;    // box A takes a share
        logic       mv_b;    // box B takes a share
    } side_t;

endpackage

`default_nettype wire

// ===== hdl/box_pair_contact_resolve.sv =====
// Throughput: one box pair per cycle with no stall on the result side;
//   the divide by 25 is a reciprocal multiply split over two pipeline stages.
// Reset: the pipeline empties and engine_running returns to 1.
// ----------------------------------------------------------------------------
// box_pair_contact_resolve: AABB contact test and separating push
// Three axis lanes test overlap and compute overlap depth, a merge stage picks
// the least axis, a divider forms the rounded share, an output stage
// saturates and packs the moves.
// ----------------------------------------------------------------------------
`default_nettype none

module box_pair_contact_resolve
    import bpcr_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration: engine_running
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    // Input pairs
    input  logic          s_tvalid,
    output logic          s_tready,
    // a_min[47:0], a_max[95:48], b_min[143:96], b_max[191:144],
    // a_event_mask[207:192], a_layer_mask[223:208],
    // b_event_mask[239:224], b_layer_mask[255:240]
    input  logic [255:0]  s_tdata,
    // a_fixed[0], b_fixed[1], a_sensor[2], b_sensor[3]
    input  logic [3:0]    s_tuser,
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    // push_axis[1:0], move_a[49:2], move_b[97:50], zero fill [103:98]
    output logic [103:0]  m_tdata,
    // contact[0], pushed[1]
    output logic [1:0]    m_tuser
);

    localparam int CW      = COORD_WIDTH;
    localparam int OW      = CW + 10;
    localparam int DW      = CW + 4;
    localparam int PW      = (3 * CW > 48) ? 3 * CW : 48;
    localparam int N       = DIV_STAGES + 5;
    localparam int ST_SUM  = 0;
    localparam int ST_OV   = 1;
    localparam int ST_SEL  = 2;
    localparam int ST_PREP = 3;
    localparam int ST_DIV  = 4;
    localparam int ST_OUT  = N - 1;

    logic              engine_running_reg;
    logic [N-1:0]      vld_reg;
    logic [N:0]        rdy;
    side_t             side_reg  [N-1];
    side_t             side_next [N-1];
    side_t             side_in;

    logic [PW-1:0]     a_min_ext, a_max_ext, b_min_ext, b_max_ext;
    logic [2:0]        lane_hit;
    logic signed [OW-1:0] lane_ov [3];
    logic              lane_dpos [3];
    logic [1:0]        mrg_axis;
    logic              mrg_neg;
    logic [DW-1:0]     mrg_dvd;
    logic [DW-1:0]     div_quo;

    logic [CW:0]       q_mag;
    logic [CW-1:0]     ma_val, mb_val;
    logic [103:0]      m_tdata_next, m_tdata_reg;
    logic [1:0]        m_tuser_next, m_tuser_reg;
    side_t             side_last;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engine_running_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            engine_running_reg <= cfg_wr_data;
        end
    end

    // Stage advance: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[N] = m_tready;
        for (int i = N - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < N; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Unpack corners, bits beyond a 48-bit field read as zero
    assign a_min_ext = PW'(s_tdata[47:0]);
    assign a_max_ext = PW'(s_tdata[95:48]);
    assign b_min_ext = PW'(s_tdata[143:96]);
    assign b_max_ext = PW'(s_tdata[191:144]);

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            bpcr_lane #(
                .CW (CW)
            ) u_lane (
                .aclk   (aclk),
                .en_sum (rdy[ST_SUM]),
                .en_ov  (rdy[ST_OV]),
                .a_min  (signed'(a_min_ext[g*CW +: CW])),
                .a_max  (signed'(a_max_ext[g*CW +: CW])),
                .b_min  (signed'(b_min_ext[g*CW +: CW])),
                .b_max  (signed'(b_max_ext[g*CW +: CW])),
                .hit    (lane_hit[g]),
                .ov     (lane_ov[g]),
                .d2_pos (lane_dpos[g])
            );
        end
    endgenerate

    // Contact and push decision at entry
    always_comb begin
        side_in         = '0;
        side_in.contact = engine_running_reg && (&lane_hit)
                          && ((s_tdata[207:192] & s_tdata[255:240]) != '0);
        side_in.pushed  = side_in.contact
                          && ((s_tdata[223:208] & s_tdata[239:224]) != '0)
                          && !s_tuser[2] && !s_tuser[3];
        side_in.mv_a    = !s_tuser[0];
        side_in.mv_b    = !s_tuser[1];
        side_in.half    = !s_tuser[0] && !s_tuser[1];
        side_in.axis    = AXIS_X;
        side_in.neg     = 1'b0;
    end

    bpcr_merge #(
        .CW (CW)
    ) u_merge (
        .aclk     (aclk),
        .en_sel   (rdy[ST_SEL]),
        .en_prep  (rdy[ST_PREP]),
        .ov       (lane_ov),
        .d2_pos   (lane_dpos),
        .half     (side_reg[ST_SEL].half),
        .axis     (mrg_axis),
        .neg      (mrg_neg),
        .dividend (mrg_dvd)
    );

    bpcr_div25 #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .en       (rdy[ST_DIV +: DIV_STAGES]),
        .dividend (mrg_dvd),
        .quotient (div_quo)
    );

    // Sideband pipeline, patched with axis and sign as they become known
    generate
        for (g = 0; g < N - 1; g++) begin : g_side
            if (g == 0) begin : g_in
                assign side_next[g] = side_in;
            end else if (g == ST_PREP) begin : g_axis
                always_comb begin
                    side_next[g]      = side_reg[g-1];
                    side_next[g].axis = mrg_axis;
                end
            end else if (g == ST_DIV) begin : g_sign
                always_comb begin
                    side_next[g]     = side_reg[g-1];
                    side_next[g].neg = mrg_neg;
                end
            end else begin : g_pass
                assign side_next[g] = side_reg[g-1];
            end

            always_ff @(posedge aclk) begin
                if (rdy[g]) begin
                    side_reg[g] <= side_next[g];
                end
            end
        end
    endgenerate

    // Saturate a signed share of magnitude qm, negated on request
    function automatic logic [CW-1:0] sat_share(input logic [CW:0] qm, input logic negate);
        logic [CW:0] half_range;
        half_range = (CW+1)'(1) << (CW - 1);
        if (negate) begin
            if (qm > half_range) begin
                sat_share = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat_share = CW'(-qm);
            end
        end else begin
            if (qm >= half_range) begin
                sat_share = {1'b0, {(CW-1){1'b1}}};
            end else begin
                sat_share = qm[CW-1:0];
            end
        end
    endfunction

    // Place one coordinate on its axis, drop bits beyond 48
    function automatic logic [47:0] pack_move(input logic [CW-1:0] val, input logic [1:0] ax);
        logic [PW-1:0] ext;
        ext = '0;
        unique case (ax)
            AXIS_X:  ext[0 +: CW]      = val;
            AXIS_Y:  ext[CW +: CW]     = val;
            AXIS_Z:  ext[2*CW +: CW]   = val;
            default: ext               = '0;
        endcase
        pack_move = ext[47:0];
    endfunction

    // Output stage: apply direction, saturate and pack
    always_comb begin
        side_last    = side_reg[ST_OUT-1];
        q_mag        = div_quo[CW:0];
        ma_val       = side_last.mv_a ? sat_share(q_mag, !side_last.neg) : '0;
        mb_val       = side_last.mv_b ? sat_share(q_mag, side_last.neg) : '0;
        m_tdata_next = '0;
        if (side_last.pushed) begin
            m_tdata_next[1:0]   = side_last.axis;
            m_tdata_next[49:2]  = pack_move(ma_val, side_last.axis);
            m_tdata_next[97:50] = pack_move(mb_val, side_last.axis);
        end
        m_tuser_next = {side_last.pushed, side_last.contact};
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A push is only ever reported with a contact
    a_push_needs_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
        else $error("push reported without contact");

    // Without a push the axis and both moves are zero
    a_idle_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0))
        else $error("nonzero move word without push");

    // Input side stalls only behind a held result
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side free");

    // Push axis is a real axis
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == AXIS_X || m_tdata[1:0] == AXIS_Y
                      || m_tdata[1:0] == AXIS_Z))
        else $error("push axis out of range");

endmodule

`default_nettype wire

// ===== hdl/bpcr_lane.sv =====
// ----------------------------------------------------------------------------
// bpcr_lane: per-axis overlap lane
// Tests inclusive overlap on one axis and computes the scaled overlap depth
// 51*S - 50*|D2| - 300 over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcr_lane
    import bpcr_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                   aclk,
    input  logic                   en_sum,
    input  logic                   en_ov,
    input  logic signed [CW-1:0]   a_min,
    input  logic signed [CW-1:0]   a_max,
    input  logic signed [CW-1:0]   b_min,
    input  logic signed [CW-1:0]   b_max,
    output logic                   hit,
    output logic signed [CW+9:0]   ov,
    output logic                   d2_pos
);

    localparam int SW = CW + 2;
    localparam int OW = CW + 10;

    logic signed [SW-1:0] s_next, s_reg;
    logic signed [SW-1:0] d2_next, d2_reg;
    logic signed [SW-1:0] ad;
    logic signed [OW-1:0] s_ext, ad_ext, ov_next, ov_reg;
    logic                 d2_pos_reg;

    // Inclusive overlap on this axis
    assign hit = !((a_max < b_min) || (a_min > b_max));

    // Sum of extents and twice the center delta
    assign s_next  = (SW'(a_max) - SW'(a_min)) + (SW'(b_max) - SW'(b_min));
    assign d2_next = (SW'(b_min) + SW'(b_max)) - (SW'(a_min) + SW'(a_max));

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            s_reg  <= s_next;
            d2_reg <= d2_next;
        end
    end

    // Scaled overlap depth
    assign ad      = d2_reg[SW-1] ? -d2_reg : d2_reg;
    assign s_ext   = OW'(s_reg);
    assign ad_ext  = OW'(ad);
    assign ov_next = s_ext * OW'(OV_S_GAIN) - ad_ext * OW'(OV_D_GAIN) - OW'(OV_MARGIN);

    always_ff @(posedge aclk) begin
        if (en_ov) begin
            ov_reg     <= ov_next;
            d2_pos_reg <= !d2_reg[SW-1] && (d2_reg != '0);
        end
    end

    assign ov     = ov_reg;
    assign d2_pos = d2_pos_reg;

endmodule

`default_nettype wire

// ===== hdl/bpcr_merge.sv =====
// ----------------------------------------------------------------------------
// bpcr_merge: least-overlap axis selection and share preparation
// Picks the axis of least overlap from the three lanes, then forms the
// rounded, pre-shifted and clamped dividend for the divide by 25.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcr_merge
    import bpcr_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                 aclk,
    input  logic                 en_sel,
    input  logic                 en_prep,
    input  logic signed [CW+9:0] ov [3],
    input  logic                 d2_pos [3],
    input  logic                 half,
    output logic [1:0]           axis,
    output logic                 neg,
    output logic [CW+3:0]        dividend
);

    localparam int OW = CW + 10;
    localparam int DW = CW + 4;
    // Clamp point: quotient 2^(CW-1)+1 saturates in either direction
    localparam logic [OW-1:0] LIM = OW'(DIV_BASE) * ((OW'(1) << (CW - 1)) + OW'(1));

    logic [1:0]           axis_next, axis_reg;
    logic signed [OW-1:0] ov_xy, ov_next, ov_reg;
    logic                 dpos_xy, dpos_next, dpos_reg;
    logic [OW-1:0]        mag, biased, shifted;
    logic                 neg_next, neg_reg;
    logic [DW-1:0]        dvd_next, dvd_reg;

    // Select least overlap, x before y before z on ties
    always_comb begin
        if (ov[1] < ov[0]) begin
            axis_next = AXIS_Y;
            ov_xy     = ov[1];
            dpos_xy   = d2_pos[1];
        end else begin
            axis_next = AXIS_X;
            ov_xy     = ov[0];
            dpos_xy   = d2_pos[0];
        end
        ov_next   = ov_xy;
        dpos_next = dpos_xy;
        if (ov[2] < ov_xy) begin
            axis_next = AXIS_Z;
            ov_next   = ov[2];
            dpos_next = d2_pos[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sel) begin
            axis_reg <= axis_next;
            ov_reg   <= ov_next;
            dpos_reg <= dpos_next;
        end
    end

    // Round to nearest with ties away from zero, fold in factor of 4 or 8
    always_comb begin
        mag      = ov_reg[OW-1] ? OW'(-ov_reg) : OW'(ov_reg);
        neg_next = dpos_reg ? ov_reg[OW-1] : !ov_reg[OW-1];
        if (half) begin
            biased  = mag + OW'(BIAS_HALF);
            shifted = biased >> SHIFT_HALF;
        end else begin
            biased  = mag + OW'(BIAS_WHOLE);
            shifted = biased >> SHIFT_WHOLE;
        end
        dvd_next = (shifted > LIM) ? DW'(LIM) : DW'(shifted);
    end

    always_ff @(posedge aclk) begin
        if (en_prep) begin
            neg_reg <= neg_next;
            dvd_reg <= dvd_next;
        end
    end

    assign axis     = axis_reg;
    assign neg      = neg_reg;
    assign dividend = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/bpcr_div25.sv =====
// ----------------------------------------------------------------------------
// bpcr_div25: pipelined divide by 25
// Multiplies by a rounded-up reciprocal of 25 scaled by 2^(DW+5) and keeps
// the upper bits. The dividend is split in two halves whose partial products
// are registered, then summed and shifted in the second stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcr_div25
    import bpcr_pkg::*;
#(
    parameter int DW = 20
) (
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [DW-1:0]         dividend,
    output logic [DW-1:0]         quotient
);

    localparam int K  = DW + 5;
    localparam int MW = DW + 1;
    localparam int HW = DW / 2;
    localparam int LW = HW + MW;
    localparam int UW = DW - HW + MW;
    localparam int PW = 2 * DW + 1;
    // Error of the reciprocal times any dividend stays below one quotient step
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << K) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE));

    logic [LW-1:0] lo_next, lo_reg;
    logic [UW-1:0] hi_next, hi_reg;
    logic [PW-1:0] prod;
    logic [DW-1:0] q_reg;

    // Partial products of the low and high dividend halves
    assign lo_next = LW'(dividend[HW-1:0]) * LW'(RECIP);
    assign hi_next = UW'(dividend[DW-1:HW]) * UW'(RECIP);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Combine the halves and keep the integer part
    assign prod = PW'(lo_reg) + (PW'(hi_reg) << HW);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            q_reg <= DW'(prod >> K);
        end
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== dv/box_pair_contact_resolve_tb.sv =====
// ----------------------------------------------------------------------------
// box_pair_contact_resolve_tb: self-checking bench for the box pair resolver
// Streams box pairs into the block and checks every result word against an
// in-bench contact and push predictor. The run covers a directed set of
// corner pairs, then random pairs that are mostly overlapping, with random
// idle gaps on both streams, long receiver holds, and engine on/off phases.
// ----------------------------------------------------------------------------
module box_pair_contact_resolve_tb;
    import bpcr_pkg::*;

    // One input word, laid out so that {s_tdata, s_tuser} is the struct itself
    typedef struct packed {
        logic [15:0] b_ly;
        logic [15:0] b_ev;
        logic [15:0] a_ly;
        logic [15:0] a_ev;
        logic [47:0] b_max;
        logic [47:0] b_min;
        logic [47:0] a_max;
        logic [47:0] a_min;
        logic        b_sensor;
        logic        a_sensor;
        logic        b_fixed;
        logic        a_fixed;
    } pair_t;

    typedef struct packed {
        logic        contact;
        logic        pushed;
        logic [1:0]  axis;
        logic [47:0] move_a;
        logic [47:0] move_b;
    } contact_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_wr_data = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [255:0]  s_tdata = '0;
    logic [3:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;
    logic [1:0]    m_tuser;

    pair_t    pair_queue[$];
    contact_t due_results[$];
    int       pairs_queued = 0;
    int       pairs_accepted = 0;
    int       fail_cnt = 0;
    bit       engine_on = 1'b1;
    bit       calm = 1'b0;
    bit       squeeze_on = 1'b0;
    int       squeeze_mark = 120;
    int       send_gap = 0;
    int       hold_left = 0;

    box_pair_contact_resolve dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Nearest integer, ties away from zero; d is positive
    function automatic longint div_round(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [47:0] pack3(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // Contact test and least-axis push for one pair
    function automatic contact_t resolve_pair(pair_t p, bit running);
        contact_t r;
        longint amin[3], amax[3], bmin[3], bmax[3], d2[3], depth[3];
        longint span, push, share_a, share_b;
        bit overlap;
        logic [1:0] ax;
        r = '0;
        overlap = 1'b1;
        for (int i = 0; i < 3; i++) begin
            amin[i] = longint'($signed(p.a_min[16*i +: 16]));
            amax[i] = longint'($signed(p.a_max[16*i +: 16]));
            bmin[i] = longint'($signed(p.b_min[16*i +: 16]));
            bmax[i] = longint'($signed(p.b_max[16*i +: 16]));
            if (amax[i] < bmin[i] || amin[i] > bmax[i]) overlap = 1'b0;
        end
        r.contact = running && overlap && ((p.a_ev & p.b_ly) != 0);
        r.pushed = r.contact && ((p.a_ly & p.b_ev) != 0) && !p.a_sensor && !p.b_sensor;
        if (!r.pushed) return r;
        // Depth in LSB/100: 0.51 of both extents, less center distance and margin
        for (int i = 0; i < 3; i++) begin
            span = (amax[i] - amin[i]) + (bmax[i] - bmin[i]);
            d2[i] = (bmin[i] + bmax[i]) - (amin[i] + amax[i]);
            depth[i] = 51 * span - 50 * (d2[i] < 0 ? -d2[i] : d2[i]) - 300;
        end
        ax = AXIS_X;
        if (depth[1] < depth[0]) ax = AXIS_Y;
        if (depth[2] < depth[ax]) ax = AXIS_Z;
        push = d2[ax] > 0 ? depth[ax] : -depth[ax];
        share_a = 0;
        share_b = 0;
        if (!p.a_fixed && !p.b_fixed) begin
            share_b = div_round(push, 200);
            share_a = -share_b;
        end else if (!p.a_fixed) begin
            share_a = -div_round(push, 100);
        end else if (!p.b_fixed) begin
            share_b = div_round(push, 100);
        end
        share_a = clamp_coord(share_a);
        share_b = clamp_coord(share_b);
        r.axis = ax;
        r.move_a = {32'd0, share_a[15:0]} << (16 * ax);
        r.move_b = {32'd0, share_b[15:0]} << (16 * ax);
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 63) == 0) calm = !calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_cnt++;
    endtask

    task automatic add_pair(pair_t p);
        pair_queue = {pair_queue, p};
        pairs_queued++;
    endtask

    task automatic wait_drained();
        while (pairs_accepted != pairs_queued || due_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_running(bit v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        engine_on = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random pairs: mostly overlapping with shared layers, some separated,
    // some thin, the rest fully random words
    task automatic queue_random(int n);
        pair_t p;
        logic [287:0] noise;
        int mode, lo, len_a, len_b, blo, k;
        repeat (n) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            p = noise[$bits(pair_t)-1:0];
            mode = $urandom_range(0, 99);
            if (mode >= 15) begin
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) begin
                    lo = $urandom_range(0, 40000) - 20000;
                    len_a = (mode < 30) ? $urandom_range(0, 4) : $urandom_range(0, 3000);
                    len_b = (mode < 30) ? $urandom_range(0, 4) : $urandom_range(0, 3000);
                    blo = lo - len_b + $urandom_range(0, len_a + len_b);
                    if (mode < 22 && i == k) begin
                        if ($urandom_range(0, 1) != 0) blo = lo + len_a + $urandom_range(1, 50);
                        else blo = lo - len_b - $urandom_range(1, 50);
                    end
                    p.a_min[16*i +: 16] = 16'(lo);
                    p.a_max[16*i +: 16] = 16'(lo + len_a);
                    p.b_min[16*i +: 16] = 16'(blo);
                    p.b_max[16*i +: 16] = 16'(blo + len_b);
                end
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 9) != 0) begin
                    p.a_ev[k] = 1'b1;
                    p.b_ly[k] = 1'b1;
                end
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 6) != 0) begin
                    p.a_ly[k] = 1'b1;
                    p.b_ev[k] = 1'b1;
                end
                p.a_sensor = ($urandom_range(0, 9) == 0);
                p.b_sensor = ($urandom_range(0, 9) == 0);
            end
            add_pair(p);
        end
    endtask

    // Drive the input stream from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0 && !squeeze_on) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pair_queue.size() != 0) begin
                {s_tdata, s_tuser} <= pair_queue.pop_front();
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result stream; hold off for a long stretch now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (pairs_accepted >= squeeze_mark) begin
            hold_left = 100;
            squeeze_on = 1'b1;
            squeeze_mark = squeeze_mark + 300;
            m_tready <= 1'b0;
        end else begin
            squeeze_on = 1'b0;
            hold_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check result words, then predict each accepted input word
    always @(posedge aclk) begin
        contact_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected word", m_tdata[63:0], '0);
            end else begin
                want = due_results.pop_front();
                if (m_tuser[0] !== want.contact)
                    flag_mismatch("contact", m_tuser[0], want.contact);
                if (m_tuser[1] !== want.pushed)
                    flag_mismatch("pushed", m_tuser[1], want.pushed);
                if (m_tdata[1:0] !== want.axis)
                    flag_mismatch("push_axis", m_tdata[1:0], want.axis);
                if (m_tdata[49:2] !== want.move_a)
                    flag_mismatch("move_a", m_tdata[49:2], want.move_a);
                if (m_tdata[97:50] !== want.move_b)
                    flag_mismatch("move_b", m_tdata[97:50], want.move_b);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            due_results = {due_results, resolve_pair(pair_t'({s_tdata, s_tuser}), engine_on)};
            pairs_accepted++;
        end
    end

    initial begin
        pair_t base, p;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_running(1'b1);

        // Directed corners; base pair overlaps least on z
        base = '0;
        base.a_ev = 16'hFFFF;
        base.a_ly = 16'hFFFF;
        base.b_ev = 16'hFFFF;
        base.b_ly = 16'hFFFF;
        base.a_min = pack3(0, 0, 0);
        base.a_max = pack3(256, 256, 256);
        base.b_min = pack3(128, 200, 250);
        base.b_max = pack3(384, 456, 506);
        add_pair(base);
        p = base; p.a_fixed = 1'b1; add_pair(p);
        p = base; p.b_fixed = 1'b1; add_pair(p);
        p = base; p.a_fixed = 1'b1; p.b_fixed = 1'b1; add_pair(p);
        p = base; p.a_sensor = 1'b1; add_pair(p);
        p = base; p.b_sensor = 1'b1; add_pair(p);
        p = base; p.a_ev = 16'h00F0; p.b_ly = 16'h0F00; add_pair(p);
        p = base; p.a_ly = 16'h0001; p.b_ev = 16'h0002; add_pair(p);
        // separated by one LSB, then touching faces
        p = base; p.b_min = pack3(257, 200, 250); p.b_max = pack3(400, 456, 506); add_pair(p);
        p = base; p.b_min = pack3(256, 200, 250); p.b_max = pack3(500, 456, 506); add_pair(p);
        // zero-size box A at the origin against a box B with max below min: no contact
        p = base; p.a_max = pack3(0, 0, 0); p.b_max = pack3(0, 0, 0); add_pair(p);
        // inverted box A
        p = base; p.a_min = pack3(256, 256, 256); p.a_max = pack3(0, 0, 0); add_pair(p);
        // full-range boxes saturate the moves
        p = base; p.a_min = pack3(-32768, -32768, -32768);
        p.a_max = pack3(32767, 32767, 32767);
        p.b_min = p.a_min; p.b_max = p.a_max; add_pair(p);
        p.a_fixed = 1'b1; add_pair(p);
        p.a_fixed = 1'b0; p.b_fixed = 1'b1; add_pair(p);
        p = base; p.a_min = pack3(32767, 32767, 32767);
        p.a_max = pack3(-32768, -32768, -32768);
        p.b_min = p.a_min; p.b_max = p.a_max; add_pair(p);
        // push toward negative x and negative y
        p = base; p.b_min = pack3(-200, 0, 0); p.b_max = pack3(56, 256, 256);
        p.b_fixed = 1'b1; add_pair(p);
        p = base; p.b_min = pack3(0, -150, 0); p.b_max = pack3(256, 106, 256); add_pair(p);
        // ties: x over y over z, then y over z
        p = base; p.b_min = p.a_min; p.b_max = p.a_max; add_pair(p);
        p = base; p.b_min = pack3(0, 100, 100); p.b_max = pack3(256, 356, 356); add_pair(p);
        p = '0; add_pair(p);
        p = '1; add_pair(p);
        wait_drained();

        queue_random(250);
        wait_drained();
        write_running(1'b0);
        queue_random(60);
        wait_drained();
        write_running(1'b1);
        queue_random(300);
        wait_drained();
        write_running(1'b0);
        queue_random(15);
        wait_drained();
        write_running(1'b1);
        queue_random(25);
        wait_drained();

        // let any stray word show up before the verdict
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0 && due_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung stream
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bpcr_pkg.sv
hdl/bpcr_lane.sv
hdl/bpcr_merge.sv
hdl/bpcr_div25.sv
hdl/box_pair_contact_resolve.sv
dv/box_pair_contact_resolve_tb.sv
